// ===== design/smie_pkg.sv =====
// ----------------------------------------------------------------------------
// smie_pkg
// shared constants, instruction codes, sequencer commands and status bundle
// ----------------------------------------------------------------------------
package smie_pkg;

  localparam int STACK_DEPTH = 2048;
  localparam int CODE_DEPTH  = 512;
  localparam int MAX_LEVELS  = 3;
  localparam int WORD_BITS   = 32;

  localparam int OPND_W = 32;
  localparam int SA_W   = $clog2(STACK_DEPTH);
  localparam int PC_W   = $clog2(CODE_DEPTH);
  localparam int EA_W   = WORD_BITS + 2;
  localparam int LV_W   = 2;
  localparam int OP_W   = 4;
  localparam int DCNT_W = $clog2(WORD_BITS);

  typedef logic [WORD_BITS-1:0] word_t;

  // opcodes
  localparam logic [OP_W-1:0] OP_LIT  = 4'd1;
  localparam logic [OP_W-1:0] OP_OPR  = 4'd2;
  localparam logic [OP_W-1:0] OP_LOD  = 4'd3;
  localparam logic [OP_W-1:0] OP_STO  = 4'd4;
  localparam logic [OP_W-1:0] OP_CAL  = 4'd5;
  localparam logic [OP_W-1:0] OP_INC  = 4'd6;
  localparam logic [OP_W-1:0] OP_JMP  = 4'd7;
  localparam logic [OP_W-1:0] OP_JPC  = 4'd8;
  localparam logic [OP_W-1:0] OP_SIO1 = 4'd9;
  localparam logic [OP_W-1:0] OP_SIO2 = 4'd10;
  localparam logic [OP_W-1:0] OP_SIO3 = 4'd11;

  // opr sub-codes
  localparam int OPR_RET = 0;
  localparam int OPR_NEG = 1;
  localparam int OPR_ADD = 2;
  localparam int OPR_SUB = 3;
  localparam int OPR_MUL = 4;
  localparam int OPR_DIV = 5;
  localparam int OPR_ODD = 6;
  localparam int OPR_MOD = 7;
  localparam int OPR_EQL = 8;
  localparam int OPR_NEQ = 9;
  localparam int OPR_LSS = 10;
  localparam int OPR_LEQ = 11;
  localparam int OPR_GTR = 12;
  localparam int OPR_GEQ = 13;

  // sio sub-codes
  localparam int SIO_WRITE = 1;
  localparam int SIO_READ  = 2;

  // error codes
  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_DIV   = 2'd1;
  localparam logic [1:0] ERR_STACK = 2'd2;

  typedef enum logic [5:0] {
    CM_NONE, CM_CLEAR, CM_LATCH, CM_WALK_INIT, CM_WALK_RD, CM_WALK_LD,
    CM_BAD, CM_NOP, CM_LIT_WR, CM_RD_BP2, CM_RD_BP3, CM_RET, CM_RD_SP,
    CM_UNARY, CM_RD_SPM1, CM_BIN_WR, CM_DIV_INIT, CM_DIV_STEP, CM_DIV_WR,
    CM_RD_EA, CM_LOD_WR, CM_STO_WR, CM_CAL1, CM_CAL2, CM_CAL3, CM_CAL4,
    CM_INC, CM_JMP, CM_JPC, CM_PRINT, CM_READ_WR, CM_HALT, CM_TOP_RD, CM_DONE
  } cmd_e;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_WALK, S_WALK_LD, S_RD_BP3, S_RET_CHK,
    S_UNARY, S_BIN_Y, S_BIN_X, S_DIV_STEP, S_DIV_WR, S_LOD_WR, S_STO_WR,
    S_CAL2, S_CAL3, S_CAL4, S_JPC, S_PRINT, S_TOP, S_DONE
  } state_e;

  typedef struct packed {
    logic            clr_last;
    logic            stopped;
    logic [OP_W-1:0] op;
    logic            sub_ret;
    logic            sub_unary;
    logic            sub_bin;
    logic            sub_div;
    logic            sio_write;
    logic            sio_read;
    logic            hops_zero;
    logic            walk_bad;
    logic            ea_bad;
    logic            sp_zero;
    logic            sp_p1_bad;
    logic            sp_p4_bad;
    logic            inc_bad;
    logic            ret_bad;
    logic            nb_bad;
    logic            div_last;
    logic            out_free;
  } dp_status_t;

endpackage

// ===== design/smie_if.sv =====
// ----------------------------------------------------------------------------
// smie channel interfaces
// instruction request channel and result request channel
// ----------------------------------------------------------------------------
interface smie_instr_if;
  logic        valid;
  logic        ready;
  logic [3:0]  opcode;
  logic [1:0]  level;
  logic [31:0] operand;
  logic [31:0] read_value;

  modport source (output valid, opcode, level, operand, read_value, input ready);
  modport sink (input valid, opcode, level, operand, read_value, output ready);
endinterface

interface smie_result_if;
  logic        valid;
  logic        ready;
  logic [8:0]  next_pc;
  logic [10:0] base_pointer;
  logic [10:0] stack_pointer;
  logic [31:0] top_value;
  logic        print_valid;
  logic [31:0] print_value;
  logic        halted;
  logic [1:0]  error_code;

  modport source (output valid, next_pc, base_pointer, stack_pointer, top_value,
                  print_valid, print_value, halted, error_code, input ready);
  modport sink (input valid, next_pc, base_pointer, stack_pointer, top_value,
                print_valid, print_value, halted, error_code, output ready);
endinterface

// ===== design/smie_ctrl.sv =====
// ----------------------------------------------------------------------------
// smie_ctrl
// sequencer: steps one instruction through the datapath by commands
// ----------------------------------------------------------------------------
module smie_ctrl
  import smie_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output cmd_e       cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o   = CM_NONE;
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        cmd_o = CM_CLEAR;
        if (status_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o   = CM_LATCH;
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_d = S_TOP;
        if (!status_i.stopped) begin
          case (status_i.op)
            OP_LIT: cmd_o = status_i.sp_p1_bad ? CM_BAD : CM_LIT_WR;
            OP_OPR: begin
              if (status_i.sub_ret) begin
                if (status_i.ret_bad) begin
                  cmd_o = CM_BAD;
                end else begin
                  cmd_o   = CM_RD_BP2;
                  state_d = S_RD_BP3;
                end
              end else if (status_i.sub_unary) begin
                cmd_o   = CM_RD_SP;
                state_d = S_UNARY;
              end else if (status_i.sub_bin) begin
                if (status_i.sp_zero) begin
                  cmd_o = CM_BAD;
                end else begin
                  cmd_o   = CM_RD_SP;
                  state_d = S_BIN_Y;
                end
              end else begin
                cmd_o = CM_NOP;
              end
            end
            OP_LOD, OP_STO, OP_CAL: begin
              cmd_o   = CM_WALK_INIT;
              state_d = S_WALK;
            end
            OP_INC: cmd_o = status_i.inc_bad ? CM_BAD : CM_INC;
            OP_JMP: cmd_o = CM_JMP;
            OP_JPC: begin
              if (status_i.sp_zero) begin
                cmd_o = CM_BAD;
              end else begin
                cmd_o   = CM_RD_SP;
                state_d = S_JPC;
              end
            end
            OP_SIO1, OP_SIO2, OP_SIO3: begin
              if (status_i.sio_write) begin
                if (status_i.sp_zero) begin
                  cmd_o = CM_BAD;
                end else begin
                  cmd_o   = CM_RD_SP;
                  state_d = S_PRINT;
                end
              end else if (status_i.sio_read) begin
                cmd_o = status_i.sp_p1_bad ? CM_BAD : CM_READ_WR;
              end else begin
                cmd_o = CM_HALT;
              end
            end
            default: cmd_o = CM_NOP;
          endcase
        end
      end
      S_WALK: begin
        if (status_i.hops_zero) begin
          state_d = S_TOP;
          case (status_i.op)
            OP_LOD: begin
              if (status_i.ea_bad || status_i.sp_p1_bad) begin
                cmd_o = CM_BAD;
              end else begin
                cmd_o   = CM_RD_EA;
                state_d = S_LOD_WR;
              end
            end
            OP_STO: begin
              if (status_i.ea_bad || status_i.sp_zero) begin
                cmd_o = CM_BAD;
              end else begin
                cmd_o   = CM_RD_SP;
                state_d = S_STO_WR;
              end
            end
            default: begin
              if (status_i.sp_p4_bad) begin
                cmd_o = CM_BAD;
              end else begin
                cmd_o   = CM_CAL1;
                state_d = S_CAL2;
              end
            end
          endcase
        end else if (status_i.walk_bad) begin
          cmd_o   = CM_BAD;
          state_d = S_TOP;
        end else begin
          cmd_o   = CM_WALK_RD;
          state_d = S_WALK_LD;
        end
      end
      S_WALK_LD: begin
        cmd_o   = CM_WALK_LD;
        state_d = S_WALK;
      end
      S_RD_BP3: begin
        cmd_o   = CM_RD_BP3;
        state_d = S_RET_CHK;
      end
      S_RET_CHK: begin
        cmd_o   = status_i.nb_bad ? CM_BAD : CM_RET;
        state_d = S_TOP;
      end
      S_UNARY: begin
        cmd_o   = CM_UNARY;
        state_d = S_TOP;
      end
      S_BIN_Y: begin
        cmd_o   = CM_RD_SPM1;
        state_d = S_BIN_X;
      end
      S_BIN_X: begin
        if (status_i.sub_div) begin
          cmd_o   = CM_DIV_INIT;
          state_d = S_DIV_STEP;
        end else begin
          cmd_o   = CM_BIN_WR;
          state_d = S_TOP;
        end
      end
      S_DIV_STEP: begin
        cmd_o = CM_DIV_STEP;
        if (status_i.div_last) state_d = S_DIV_WR;
      end
      S_DIV_WR: begin
        cmd_o   = CM_DIV_WR;
        state_d = S_TOP;
      end
      S_LOD_WR: begin
        cmd_o   = CM_LOD_WR;
        state_d = S_TOP;
      end
      S_STO_WR: begin
        cmd_o   = CM_STO_WR;
        state_d = S_TOP;
      end
      S_CAL2: begin
        cmd_o   = CM_CAL2;
        state_d = S_CAL3;
      end
      S_CAL3: begin
        cmd_o   = CM_CAL3;
        state_d = S_CAL4;
      end
      S_CAL4: begin
        cmd_o   = CM_CAL4;
        state_d = S_TOP;
      end
      S_JPC: begin
        cmd_o   = CM_JPC;
        state_d = S_TOP;
      end
      S_PRINT: begin
        cmd_o   = CM_PRINT;
        state_d = S_TOP;
      end
      S_TOP: begin
        cmd_o   = CM_TOP_RD;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (status_i.out_free) begin
          cmd_o   = CM_DONE;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ===== design/smie_dp.sv =====
// ----------------------------------------------------------------------------
// smie_dp
// datapath: machine registers, stack memory, alu, divider, result register
// ----------------------------------------------------------------------------
module smie_dp
  import smie_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cmd_e                     cmd_i,
  output dp_status_t               status_o,
  input  logic [OP_W-1:0]          opcode_i,
  input  logic [LV_W-1:0]          level_i,
  input  logic [OPND_W-1:0]        operand_i,
  input  logic [OPND_W-1:0]        read_value_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [PC_W-1:0]          next_pc_o,
  output logic [SA_W-1:0]          base_pointer_o,
  output logic [SA_W-1:0]          stack_pointer_o,
  output logic [WORD_BITS-1:0]     top_value_o,
  output logic                     print_valid_o,
  output logic [WORD_BITS-1:0]     print_value_o,
  output logic                     halted_o,
  output logic [1:0]               error_code_o
);

  // machine registers
  logic [PC_W-1:0] pc_q;
  logic [SA_W-1:0] bp_q, sp_q, clr_q;
  logic            stop_q, out_valid_q;

  // instruction and work registers
  logic [OP_W-1:0]          op_q;
  logic [LV_W-1:0]          hop_q;
  logic [LV_W-1:0]          lv_q;
  logic signed [OPND_W-1:0] m_q;
  logic [OPND_W-1:0]        rv_q;
  word_t                    b_q, x_q, y_q, rd_q, pval_q;
  logic                     pv_q;
  logic [1:0]               err_q;

  // divider
  word_t                dq_q, dd_q;
  logic [WORD_BITS:0]   dr_q;
  logic [DCNT_W-1:0]    dcnt_q;

  word_t stack_q [STACK_DEPTH];

  logic signed [EA_W-1:0] b_ext, m_ext, sp_ext, bp_ext, x_ext, ea;
  logic [PC_W-1:0]        pc_inc;
  logic [SA_W-1:0]        mem_addr;
  logic                   mem_we, mem_re;
  word_t                  mem_wdata, alu_res, div_res, un_res;
  logic [WORD_BITS:0]     dr_sh;
  logic                   dr_ge;
  logic                   is_div;

  function automatic logic in_stack(logic signed [EA_W-1:0] v);
    return (v >= 0) && (v < $signed(EA_W'(STACK_DEPTH)));
  endfunction

  assign b_ext  = EA_W'($signed(b_q));
  assign x_ext  = EA_W'($signed(x_q));
  assign m_ext  = EA_W'(m_q);
  assign sp_ext = $signed(EA_W'(sp_q));
  assign bp_ext = $signed(EA_W'(bp_q));
  assign ea     = b_ext + m_ext;
  assign pc_inc = pc_q + PC_W'(1);
  assign is_div = (m_q == OPR_DIV);

  // status toward the sequencer
  always_comb begin
    status_o.clr_last  = (clr_q == SA_W'(STACK_DEPTH - 1));
    status_o.stopped   = stop_q;
    status_o.op        = op_q;
    status_o.sub_ret   = (m_q == OPR_RET);
    status_o.sub_unary = (m_q == OPR_NEG) || (m_q == OPR_ODD);
    status_o.sub_bin   = (m_q >= OPR_ADD) && (m_q <= OPR_GEQ) && (m_q != OPR_ODD);
    status_o.sub_div   = (m_q == OPR_DIV) || (m_q == OPR_MOD);
    status_o.sio_write = (m_q == SIO_WRITE);
    status_o.sio_read  = (m_q == SIO_READ);
    status_o.hops_zero = (hop_q == '0);
    status_o.walk_bad  = !in_stack(b_ext + EA_W'(1));
    status_o.ea_bad    = !in_stack(ea);
    status_o.sp_zero   = (sp_q == '0);
    status_o.sp_p1_bad = !in_stack(sp_ext + EA_W'(1));
    status_o.sp_p4_bad = !in_stack(sp_ext + EA_W'(4));
    status_o.inc_bad   = !in_stack(sp_ext + m_ext);
    status_o.ret_bad   = (bp_q == '0) || !in_stack(bp_ext + EA_W'(3));
    status_o.nb_bad    = !in_stack(x_ext);
    status_o.div_last  = (dcnt_q == DCNT_W'(WORD_BITS - 1));
    status_o.out_free  = !out_valid_q || out_ready_i;
  end

  // alu on x = rd_q (stack[sp-1]) and y = y_q (stack[sp])
  always_comb begin
    case (m_q)
      OPR_ADD: alu_res = rd_q + y_q;
      OPR_SUB: alu_res = rd_q - y_q;
      OPR_MUL: alu_res = rd_q * y_q;
      OPR_EQL: alu_res = word_t'(rd_q == y_q);
      OPR_NEQ: alu_res = word_t'(rd_q != y_q);
      OPR_LSS: alu_res = word_t'($signed(rd_q) < $signed(y_q));
      OPR_LEQ: alu_res = word_t'($signed(rd_q) <= $signed(y_q));
      OPR_GTR: alu_res = word_t'($signed(rd_q) > $signed(y_q));
      default: alu_res = word_t'($signed(rd_q) >= $signed(y_q));
    endcase
    un_res = (m_q == OPR_NEG) ? word_t'(-rd_q) : (rd_q & word_t'(1));
  end

  // divider result with the zero and minus-one cases
  always_comb begin
    if (y_q == '0) begin
      div_res = is_div ? '0 : x_q;
    end else if (y_q == '1) begin
      div_res = is_div ? word_t'(-x_q) : '0;
    end else if (is_div) begin
      div_res = (x_q[WORD_BITS-1] ^ y_q[WORD_BITS-1]) ? word_t'(-dq_q) : dq_q;
    end else begin
      div_res = x_q[WORD_BITS-1] ? word_t'(-dr_q[WORD_BITS-1:0]) : dr_q[WORD_BITS-1:0];
    end
  end

  assign dr_sh = {dr_q[WORD_BITS-1:0], dq_q[WORD_BITS-1]};
  assign dr_ge = (dr_sh >= {1'b0, dd_q});

  // memory port
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = sp_q;
    mem_wdata = '0;
    case (cmd_i)
      CM_CLEAR:   begin mem_we = 1'b1; mem_addr = clr_q; end
      CM_WALK_RD: begin mem_re = 1'b1; mem_addr = SA_W'(b_ext + EA_W'(1)); end
      CM_RD_BP2:  begin mem_re = 1'b1; mem_addr = bp_q + SA_W'(2); end
      CM_RD_BP3:  begin mem_re = 1'b1; mem_addr = bp_q + SA_W'(3); end
      CM_RD_SP, CM_TOP_RD: mem_re = 1'b1;
      CM_UNARY:   begin mem_we = 1'b1; mem_wdata = un_res; end
      CM_RD_SPM1: begin mem_re = 1'b1; mem_addr = sp_q - SA_W'(1); end
      CM_BIN_WR:  begin mem_we = 1'b1; mem_addr = sp_q - SA_W'(1); mem_wdata = alu_res; end
      CM_DIV_WR:  begin mem_we = 1'b1; mem_addr = sp_q - SA_W'(1); mem_wdata = div_res; end
      CM_RD_EA:   begin mem_re = 1'b1; mem_addr = SA_W'(ea); end
      CM_STO_WR:  begin mem_we = 1'b1; mem_addr = SA_W'(ea); mem_wdata = rd_q; end
      CM_LIT_WR:  begin
        mem_we = 1'b1; mem_addr = sp_q + SA_W'(1); mem_wdata = word_t'(m_q);
      end
      CM_LOD_WR:  begin mem_we = 1'b1; mem_addr = sp_q + SA_W'(1); mem_wdata = rd_q; end
      CM_READ_WR: begin
        mem_we = 1'b1; mem_addr = sp_q + SA_W'(1); mem_wdata = word_t'(rv_q);
      end
      CM_CAL1:    begin mem_we = 1'b1; mem_addr = sp_q + SA_W'(1); end
      CM_CAL2:    begin mem_we = 1'b1; mem_addr = sp_q + SA_W'(2); mem_wdata = b_q; end
      CM_CAL3:    begin
        mem_we = 1'b1; mem_addr = sp_q + SA_W'(3); mem_wdata = word_t'(bp_q);
      end
      CM_CAL4:    begin
        mem_we = 1'b1; mem_addr = sp_q + SA_W'(4); mem_wdata = word_t'(pc_inc);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) stack_q[mem_addr] <= mem_wdata;
    if (mem_re) rd_q <= stack_q[mem_addr];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= '0;
      bp_q        <= SA_W'(1);
      sp_q        <= '0;
      stop_q      <= 1'b0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      case (cmd_i)
        CM_CLEAR: clr_q <= clr_q + SA_W'(1);
        CM_BAD, CM_NOP, CM_UNARY: pc_q <= pc_inc;
        CM_LIT_WR, CM_LOD_WR, CM_READ_WR: begin
          pc_q <= pc_inc;
          sp_q <= sp_q + SA_W'(1);
        end
        CM_BIN_WR, CM_DIV_WR, CM_STO_WR, CM_PRINT: begin
          pc_q <= pc_inc;
          sp_q <= sp_q - SA_W'(1);
        end
        CM_RET: begin
          sp_q   <= bp_q - SA_W'(1);
          pc_q   <= rd_q[PC_W-1:0];
          bp_q   <= x_q[SA_W-1:0];
          stop_q <= (x_q == '0);
        end
        CM_CAL4: begin
          bp_q <= sp_q + SA_W'(1);
          pc_q <= m_q[PC_W-1:0];
        end
        CM_INC: begin
          pc_q <= pc_inc;
          sp_q <= SA_W'(sp_ext + m_ext);
        end
        CM_JMP: pc_q <= m_q[PC_W-1:0];
        CM_JPC: begin
          pc_q <= (rd_q == '0) ? m_q[PC_W-1:0] : pc_inc;
          sp_q <= sp_q - SA_W'(1);
        end
        CM_HALT: begin
          pc_q   <= '0;
          bp_q   <= '0;
          sp_q   <= '0;
          stop_q <= 1'b1;
        end
        default: ;
      endcase
      if (cmd_i == CM_DONE) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (cmd_i)
      CM_LATCH: begin
        op_q   <= opcode_i;
        lv_q   <= level_i;
        m_q    <= $signed(operand_i);
        rv_q   <= read_value_i;
        err_q  <= ERR_NONE;
        pv_q   <= 1'b0;
        pval_q <= '0;
      end
      CM_WALK_INIT: begin
        b_q   <= word_t'(bp_q);
        hop_q <= (int'(lv_q) > MAX_LEVELS) ? LV_W'(MAX_LEVELS) : lv_q;
      end
      CM_WALK_LD: begin
        b_q   <= rd_q;
        hop_q <= hop_q - LV_W'(1);
      end
      CM_RD_BP3:  x_q <= rd_q;
      CM_RD_SPM1: y_q <= rd_q;
      CM_BAD:     err_q <= ERR_STACK;
      CM_DIV_INIT: begin
        x_q    <= rd_q;
        dq_q   <= rd_q[WORD_BITS-1] ? word_t'(-rd_q) : rd_q;
        dd_q   <= y_q[WORD_BITS-1] ? word_t'(-y_q) : y_q;
        dr_q   <= '0;
        dcnt_q <= '0;
      end
      CM_DIV_STEP: begin
        dr_q   <= dr_ge ? (dr_sh - {1'b0, dd_q}) : dr_sh;
        dq_q   <= {dq_q[WORD_BITS-2:0], dr_ge};
        dcnt_q <= dcnt_q + DCNT_W'(1);
      end
      CM_DIV_WR:  if (y_q == '0) err_q <= ERR_DIV;
      CM_PRINT: begin
        pv_q   <= 1'b1;
        pval_q <= rd_q;
      end
      CM_DONE: begin
        next_pc_o       <= pc_q;
        base_pointer_o  <= bp_q;
        stack_pointer_o <= sp_q;
        top_value_o     <= rd_q;
        print_valid_o   <= pv_q;
        print_value_o   <= pval_q;
        halted_o        <= stop_q;
        error_code_o    <= err_q;
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== design/stack_machine_instruction_executor_core.sv =====
// ----------------------------------------------------------------------------
// stack_machine_instruction_executor_core
// p-code stack machine that executes one supplied instruction per request
// ----------------------------------------------------------------------------
// usage
//   instr_i carries one instruction request (opcode, level, operand and the
//   word for an input operation); the caller fetches it from code[next_pc]
//   of the previous result. result_o returns one request per instruction with
//   pc, bp, sp, the word at the stack top, print data, halted and error code.
//   the stack memory has a single port, one access per cycle, so every
//   instruction steps through its reads and writes one at a time; divide and
//   modulo produce one quotient bit per cycle; load, store and call walk the
//   static links one hop at a time, each hop a stack read and a register load.
//   one instruction is in flight at a time; ready is high only while idle.
//   after reset a clearing pass zeroes the stack memory, during which no
//   instruction is taken.
//   results sit in an output register; a stalled receiver holds the result
//   and the next instruction may still run until its own result is ready.
// ----------------------------------------------------------------------------
module stack_machine_instruction_executor_core
  import smie_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  smie_instr_if.sink   instr_i,
  smie_result_if.source result_o
);

  // command and status between sequencer and datapath
  cmd_e       cmd;
  dp_status_t status;
  logic       in_ready;

  smie_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (instr_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // ready follows the idle state of the sequencer
  assign instr_i.ready = in_ready;

  smie_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .opcode_i        (instr_i.opcode),
    .level_i         (instr_i.level),
    .operand_i       (instr_i.operand),
    .read_value_i    (instr_i.read_value),
    .out_valid_o     (result_o.valid),
    .out_ready_i     (result_o.ready),
    .next_pc_o       (result_o.next_pc),
    .base_pointer_o  (result_o.base_pointer),
    .stack_pointer_o (result_o.stack_pointer),
    .top_value_o     (result_o.top_value),
    .print_valid_o   (result_o.print_valid),
    .print_value_o   (result_o.print_value),
    .halted_o        (result_o.halted),
    .error_code_o    (result_o.error_code)
  );

endmodule

// ===== test/stack_machine_instruction_executor_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_machine_instruction_executor_core_tb
// instruction-level self-checking bench for the p-code stack machine
// ----------------------------------------------------------------------------
// every accepted instruction is run through a local model of pc, bp, sp,
// the halted flag and the stack words. The expected result is queued and
// compared field by field with each result request. Directed programs cover
// arithmetic corners, frames and the error codes. A guided random program
// follows, then a long output stall and finally a halt.
// ----------------------------------------------------------------------------
module stack_machine_instruction_executor_core_tb;
  import smie_pkg::*;

  localparam int          IDLE_LIMIT = 6000;
  localparam int          LONG_HOLD  = 300;
  localparam logic [3:0]  OP_NONE    = 4'd0;

  typedef struct {
    logic [8:0]  pc;
    logic [10:0] bp;
    logic [10:0] sp;
    logic [31:0] top;
    logic        pv;
    logic [31:0] pval;
    logic        halted;
    logic [1:0]  err;
  } step_t;

  logic clk_i;
  logic rst_ni;

  smie_instr_if  instr ();
  smie_result_if res ();

  stack_machine_instruction_executor_core u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .instr_i (instr),
    .result_o(res)
  );

  // machine model state
  logic [31:0] stack_words [STACK_DEPTH];
  logic [8:0]  pc_q;
  logic [10:0] bp_q;
  logic [10:0] sp_q;
  bit          halted_q;

  step_t expected_q[$];
  int    fail_cnt;
  int    idle_cnt;
  int    stall_left;
  bit    quiet;
  bit    long_hold;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint sword(input logic [31:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic bit in_stack(input longint s);
    return s >= 0 && s < STACK_DEPTH;
  endfunction

  // signed target folded into the code space
  function automatic logic [8:0] code_addr(input longint v);
    longint r;
    r = v % CODE_DEPTH;
    if (r < 0) r += CODE_DEPTH;
    return r[8:0];
  endfunction

  // follow static links from the current base
  function automatic bit walk_links(input int hops, output longint base);
    longint x;
    x = bp_q;
    for (int i = 0; i < hops; i++) begin
      if (!in_stack(x + 1)) return 1'b0;
      x = sword(stack_words[int'(x + 1)]);
    end
    base = x;
    return 1'b1;
  endfunction

  function automatic logic [31:0] alu(input int sub, input logic [31:0] x,
                                     input logic [31:0] y, inout logic [1:0] err);
    longint xs, ys;
    xs = sword(x);
    ys = sword(y);
    case (sub)
      OPR_ADD: return x + y;
      OPR_SUB: return x - y;
      OPR_MUL: return x * y;
      OPR_DIV: begin
        if (ys == 0) begin
          err = ERR_DIV;
          return '0;
        end
        if (ys == -1) return -x;
        return 32'(xs / ys);
      end
      OPR_MOD: begin
        if (ys == 0) begin
          err = ERR_DIV;
          return x;
        end
        if (ys == -1) return '0;
        return 32'(xs % ys);
      end
      OPR_EQL: return 32'(xs == ys);
      OPR_NEQ: return 32'(xs != ys);
      OPR_LSS: return 32'(xs < ys);
      OPR_LEQ: return 32'(xs <= ys);
      OPR_GTR: return 32'(xs > ys);
      default: return 32'(xs >= ys);
    endcase
  endfunction

  // one instruction on the model; with commit clear only tells if it stops
  function automatic void exec_instr(input logic [3:0] op, input logic [1:0] lv,
                                     input logic [31:0] opnd, input logic [31:0] rdv,
                                     input bit commit, output step_t r, output bit stops);
    longint      ms, b, nb;
    int          sp, bp, nw;
    int          wa [4];
    logic [31:0] wd [4];
    logic [8:0]  npc;
    int          nsp, nbp;
    bit          bad, stop, pv;
    logic [31:0] pval;
    logic [1:0]  err;
    stops = 1'b0;
    r = '{pc_q, bp_q, sp_q, stack_words[sp_q], 1'b0, '0, 1'b1, ERR_NONE};
    if (halted_q) return;
    ms = sword(opnd);
    sp = sp_q;
    bp = bp_q;
    npc = pc_q + 9'd1;
    nsp = sp;
    nbp = bp;
    bad = 0; stop = 0; pv = 0; pval = '0; err = ERR_NONE; nw = 0;
    case (op)
      OP_LIT: begin
        if (!in_stack(sp + 1)) bad = 1;
        else begin
          wa[0] = sp + 1; wd[0] = opnd; nw = 1; nsp = sp + 1;
        end
      end
      OP_OPR: begin
        if (ms == OPR_RET) begin
          if (!in_stack(bp - 1) || !in_stack(bp + 3)) bad = 1;
          else begin
            nb = sword(stack_words[bp + 2]);
            if (!in_stack(nb)) bad = 1;
            else begin
              nsp = bp - 1;
              npc = code_addr(sword(stack_words[bp + 3]));
              nbp = int'(nb);
              stop = (nb == 0);
            end
          end
        end else if (ms == OPR_NEG) begin
          wa[0] = sp; wd[0] = -stack_words[sp]; nw = 1;
        end else if (ms == OPR_ODD) begin
          wa[0] = sp; wd[0] = stack_words[sp] & 32'd1; nw = 1;
        end else if (ms >= OPR_ADD && ms <= OPR_GEQ) begin
          if (sp == 0) bad = 1;
          else begin
            wa[0] = sp - 1;
            wd[0] = alu(int'(ms), stack_words[sp - 1], stack_words[sp], err);
            nw = 1;
            nsp = sp - 1;
          end
        end
      end
      OP_LOD: begin
        if (!walk_links(lv, b) || !in_stack(b + ms) || !in_stack(sp + 1)) bad = 1;
        else begin
          wa[0] = sp + 1; wd[0] = stack_words[int'(b + ms)]; nw = 1; nsp = sp + 1;
        end
      end
      OP_STO: begin
        if (!walk_links(lv, b) || !in_stack(b + ms) || sp == 0) bad = 1;
        else begin
          wa[0] = int'(b + ms); wd[0] = stack_words[sp]; nw = 1; nsp = sp - 1;
        end
      end
      OP_CAL: begin
        if (!walk_links(lv, b) || !in_stack(sp + 4)) bad = 1;
        else begin
          wa[0] = sp + 1; wd[0] = '0;
          wa[1] = sp + 2; wd[1] = b[31:0];
          wa[2] = sp + 3; wd[2] = 32'(bp);
          wa[3] = sp + 4; wd[3] = 32'(npc);
          nw = 4;
          nbp = sp + 1;
          npc = code_addr(ms);
        end
      end
      OP_INC: begin
        if (!in_stack(sp + ms)) bad = 1;
        else nsp = int'(sp + ms);
      end
      OP_JMP: npc = code_addr(ms);
      OP_JPC: begin
        if (sp == 0) bad = 1;
        else begin
          if (stack_words[sp] == '0) npc = code_addr(ms);
          nsp = sp - 1;
        end
      end
      OP_SIO1, OP_SIO2, OP_SIO3: begin
        if (ms == SIO_WRITE) begin
          if (sp == 0) bad = 1;
          else begin
            pv = 1; pval = stack_words[sp]; nsp = sp - 1;
          end
        end else if (ms == SIO_READ) begin
          if (!in_stack(sp + 1)) bad = 1;
          else begin
            wa[0] = sp + 1; wd[0] = rdv; nw = 1; nsp = sp + 1;
          end
        end else begin
          npc = '0; nsp = 0; nbp = 0; stop = 1;
        end
      end
      default: ;
    endcase
    stops = stop && !bad;
    if (!commit) return;
    if (bad) begin
      err = ERR_STACK;
      pv = 0;
      pval = '0;
      pc_q = pc_q + 9'd1;
    end else begin
      for (int i = 0; i < nw; i++) stack_words[wa[i]] = wd[i];
      pc_q = npc;
      sp_q = nsp[10:0];
      bp_q = nbp[10:0];
      if (stop) halted_q = 1'b1;
    end
    r = '{pc_q, bp_q, sp_q, stack_words[sp_q], pv, pval, halted_q, err};
  endfunction

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------

  // offer one instruction request, hold it until taken, then predict it
  task automatic send_instr(input logic [3:0] op, input logic [1:0] lv,
                            input logic [31:0] opnd, input logic [31:0] rdv);
    int    gap;
    step_t r;
    bit    s;
    gap = quiet ? 0 : $urandom_range(0, 12);
    repeat (gap) begin
      @(negedge clk_i);
      instr.valid = 1'b0;
    end
    @(negedge clk_i);
    instr.valid      = 1'b1;
    instr.opcode     = op;
    instr.level      = lv;
    instr.operand    = opnd;
    instr.read_value = rdv;
    do @(posedge clk_i); while (!instr.ready);
    exec_instr(op, lv, opnd, rdv, 1'b1, r, s);
    expected_q.push_back(r);
  endtask

  // random program must not stop the machine early, so stopping requests
  // are turned into unknown opcodes
  task automatic send_running(input logic [3:0] op, input logic [1:0] lv,
                              input logic [31:0] opnd, input logic [31:0] rdv);
    step_t r;
    bit    s;
    exec_instr(op, lv, opnd, rdv, 1'b0, r, s);
    send_instr(s ? OP_NONE : op, lv, opnd, rdv);
  endtask

  // pause offering until every result has come back
  task automatic drain();
    @(negedge clk_i);
    instr.valid = 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'($urandom_range(0, 4)) - 32'd2;
      2: case ($urandom_range(0, 3))
           0: return 32'h8000_0000;
           1: return 32'h7fff_ffff;
           2: return 32'h0;
           default: return 32'hffff_ffff;
         endcase
      default: return $urandom_range(0, 100);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  // receiver stalls: a fresh random hold after each result, or a long hold
  initial begin
    res.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold) begin
        long_hold = 1'b0;
        res.ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
      end
      if (stall_left > 0) begin
        res.ready = 1'b0;
        stall_left--;
      end else begin
        res.ready = 1'b1;
      end
    end
  end

  function automatic void cmp_field(input string name, input logic [31:0] e,
                                    input logic [31:0] a);
    if (e !== a) begin
      $display("%0t mismatch %s: expected %h actual %h", $time, name, e, a);
      fail_cnt++;
    end
  endfunction

  always @(posedge clk_i) begin
    step_t e;
    if (rst_ni && res.valid && res.ready) begin
      stall_left = quiet ? 0 : $urandom_range(0, 12);
      if (expected_q.size() == 0) begin
        $display("%0t unexpected result request: expected none actual pc %h",
                 $time, res.next_pc);
        fail_cnt++;
      end else begin
        e = expected_q.pop_front();
        cmp_field("next_pc", 32'(e.pc), 32'(res.next_pc));
        cmp_field("base_pointer", 32'(e.bp), 32'(res.base_pointer));
        cmp_field("stack_pointer", 32'(e.sp), 32'(res.stack_pointer));
        cmp_field("top_value", e.top, res.top_value);
        cmp_field("print_valid", 32'(e.pv), 32'(res.print_valid));
        cmp_field("print_value", e.pval, res.print_value);
        cmp_field("halted", 32'(e.halted), 32'(res.halted));
        cmp_field("error_code", 32'(e.err), 32'(res.error_code));
      end
    end
  end

  // watchdog on cycles without any handshake, covers the clearing pass too
  always @(posedge clk_i) begin
    if ((instr.valid && instr.ready) || (res.valid && res.ready)) begin
      idle_cnt = 0;
    end else if (++idle_cnt >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // arithmetic corners on the expression stack
  task automatic test_arith();
    send_instr(OP_OPR, 2'd0, OPR_ADD, '0);          // pop from empty stack
    send_instr(OP_LIT, 2'd0, 32'h7fff_ffff, '0);
    send_instr(OP_LIT, 2'd0, 32'd1, '0);
    send_instr(OP_OPR, 2'd0, OPR_ADD, '0);          // wraps to most negative
    send_instr(OP_LIT, 2'd0, 32'hffff_ffff, '0);
    send_instr(OP_OPR, 2'd0, OPR_DIV, '0);          // divide by minus one
    send_instr(OP_LIT, 2'd0, 32'd0, '0);
    send_instr(OP_OPR, 2'd0, OPR_MOD, '0);          // modulo by zero keeps dividend
    send_instr(OP_LIT, 2'd0, 32'd0, '0);
    send_instr(OP_OPR, 2'd0, OPR_DIV, '0);          // divide by zero gives 0
    send_instr(OP_LIT, 2'd0, 32'hffff_fff9, '0);
    send_instr(OP_LIT, 2'd0, 32'hffff_ffff, '0);
    send_instr(OP_OPR, 2'd0, OPR_MOD, '0);          // modulo by minus one
    for (int s = OPR_NEG; s <= OPR_GEQ; s++) begin
      send_instr(OP_LIT, 2'd0, pick_word(), '0);
      send_instr(OP_OPR, 2'd0, s, '0);
    end
    send_instr(OP_OPR, 2'd0, 32'd14, '0);           // unknown sub-codes
    send_instr(OP_OPR, 2'd0, 32'hffff_ffff, '0);
  endtask

  // frames, static links, jumps, i/o and the stack range errors
  task automatic test_frames();
    send_instr(OP_INC, 2'd0, 32'd6, '0);
    send_instr(OP_LIT, 2'd0, 32'd42, '0);
    send_instr(OP_STO, 2'd0, 32'd4, '0);
    send_instr(OP_CAL, 2'd0, 32'hffff_fffd, '0);    // negative target wraps
    send_instr(OP_INC, 2'd0, 32'd4, '0);
    send_instr(OP_LOD, 2'd1, 32'd4, '0);
    send_instr(OP_STO, 2'd2, 32'd5, '0);
    send_instr(OP_LOD, 2'd3, 32'h7fff_ffff, '0);    // address far off the stack
    send_instr(OP_OPR, 2'd0, OPR_RET, '0);
    send_instr(OP_INC, 2'd0, 32'h8000_0000, '0);
    send_instr(OP_JMP, 2'd0, 32'hffff_ffff, '0);
    send_instr(OP_LIT, 2'd0, 32'd0, '0);
    send_instr(OP_JPC, 2'd0, 32'd100, '0);          // taken
    send_instr(OP_LIT, 2'd0, 32'd5, '0);
    send_instr(OP_JPC, 2'd0, 32'd0, '0);            // not taken
    send_instr(OP_SIO2, 2'd0, SIO_READ, 32'h8000_0001);
    send_instr(OP_SIO2, 2'd0, SIO_WRITE, '0);
    send_instr(OP_SIO1, 2'd0, SIO_READ, 32'h7fff_fffe);
    send_instr(OP_SIO3, 2'd0, SIO_WRITE, '0);
    send_instr(OP_NONE, 2'd3, 32'hffff_ffff, 32'hffff_ffff);
    send_instr(4'd15, 2'd0, '0, '0);
    drain();
  endtask

  // guided random program: mostly well-formed with random content
  task automatic test_random(input int n);
    logic [3:0]  op;
    logic [1:0]  lv;
    logic [31:0] m;
    int          k;
    for (int i = 0; i < n; i++) begin
      if (i % 100 == 0) quiet = ($urandom_range(0, 3) == 0);
      lv = 2'($urandom);
      k = $urandom_range(0, 99);
      if (k < 20) begin
        op = OP_LIT; m = pick_word();
      end else if (k < 45) begin
        op = OP_OPR;
        m = $urandom_range(1, 13);
        if ($urandom_range(0, 9) == 0) m = OPR_RET;
        if (sp_q > 1900) m = OPR_ADD;
      end else if (k < 63) begin
        op = (k < 55) ? OP_LOD : OP_STO;
        m = ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 7);
      end else if (k < 68) begin
        // call followed by the usual frame allocation
        send_running(OP_CAL, lv, $urandom_range(0, 511), $urandom);
        op = OP_INC; m = 32'd4;
      end else if (k < 74) begin
        op = OP_INC; m = 32'($urandom_range(0, 5)) - 32'd2;
      end else if (k < 78) begin
        op = OP_JMP; m = $urandom;
      end else if (k < 85) begin
        op = OP_JPC; m = $urandom;
      end else if (k < 95) begin
        op = 4'($urandom_range(OP_SIO1, OP_SIO3)); m = $urandom_range(1, 2);
      end else begin
        op = 4'($urandom); m = $urandom;
      end
      send_running(op, lv, m, $urandom);
    end
    quiet = 1'b0;
    drain();
  endtask

  // receiver holds off while requests keep coming, so the input stalls
  task automatic test_backpressure();
    long_hold = 1'b1;
    for (int i = 0; i < 20; i++) send_running(OP_LIT, 2'($urandom), $urandom, $urandom);
    drain();
  endtask

  // halt through an input operation, then stopped machine ignores requests
  task automatic test_halt();
    send_instr(OP_SIO3, 2'd0, 32'h8000_0000, '0);
    send_instr(OP_LIT, 2'd0, 32'd9, '0);
    send_instr(OP_SIO1, 2'd0, SIO_WRITE, '0);
    send_instr(OP_OPR, 2'd0, OPR_RET, '0);
    drain();
  endtask

  initial begin
    fail_cnt   = 0;
    idle_cnt   = 0;
    stall_left = 0;
    quiet      = 1'b0;
    long_hold  = 1'b0;
    foreach (stack_words[i]) stack_words[i] = '0;
    pc_q     = '0;
    bp_q     = 11'd1;
    sp_q     = '0;
    halted_q = 1'b0;
    instr.valid      = 1'b0;
    instr.opcode     = '0;
    instr.level      = '0;
    instr.operand    = '0;
    instr.read_value = '0;
    rst_ni = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    test_arith();
    test_frames();
    test_random(700);
    test_backpressure();
    test_halt();

    repeat (60) @(posedge clk_i);
    if (fail_cnt == 0 && expected_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
